>>> rtl/core/zrld_pkg.sv
// Shared types and constants of the zero run-length decoder.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package zrld_pkg;

    // Width of the run accumulator (holds the run length plus one, built from the bijective digits taken in).
    localparam int COUNT_WIDTH = 32;
    // Width used to compare a raw run length against the remaining bytes.
    localparam int CMP_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    localparam int BYTE_WIDTH = 8;
    localparam int LEN_WIDTH = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CODING_MODE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BORDER_SYMBOL = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_SIZE = 2'd2;

    // Coding modes.
    localparam logic MODE_COUNT_BYTE = 1'b0;
    localparam logic MODE_BIJECTIVE = 1'b1;

    // Result kinds.
    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    // One decoded input byte: an optional clipped zero run followed by an
    // optional literal. Each part carries its own full flag.
    typedef struct packed {
        logic                  has_run;
        logic [LEN_WIDTH-1:0]  run_len;
        logic                  run_full;
        logic                  has_lit;
        logic [BYTE_WIDTH-1:0] lit_val;
        logic                  lit_full;
    } zrld_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } zrld_q_status_t;

endpackage

>>> rtl/core/zrld_front.sv
// Front end of the zero run-length decoder: configuration registers, byte
// classification, run accumulation and output size clipping.
// Depends on zrld_pkg.
module zrld_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [zrld_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [zrld_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [zrld_pkg::BYTE_WIDTH-1:0]         code_byte,
    input  logic                                    end_of_stream,
    input  zrld_pkg::zrld_q_status_t                q_status,
    output logic                                    push,
    output zrld_pkg::zrld_cmd_t                     push_cmd
);
    import zrld_pkg::*;

    logic                  mode_reg;
    logic [BYTE_WIDTH-1:0] border_reg;
    logic [LEN_WIDTH-1:0]  produced_reg;
    logic [LEN_WIDTH-1:0]  produced_next;
    logic [LEN_WIDTH-1:0]  remain_reg;
    logic [LEN_WIDTH-1:0]  remain_next;
    logic                  run_open_reg;
    logic                  run_open_next;
    logic [COUNT_WIDTH-1:0] acc_reg;
    logic [COUNT_WIDTH-1:0] acc_next;
    logic                  await_reg;
    logic                  await_next;

    logic                   accept;
    logic                   active;
    logic                   is_digit;
    logic [COUNT_WIDTH-1:0] acc_grown;
    logic [COUNT_WIDTH-1:0] acc_sel;
    logic [COUNT_WIDTH-1:0] run_raw;
    logic                   has_run_raw;
    logic                   has_lit_raw;
    logic [BYTE_WIDTH-1:0]  lit_val;
    logic [CMP_WIDTH-1:0]   run_ext;
    logic                   run_ge;
    logic [LEN_WIDTH-1:0]   run_clip;
    logic                   run_emit;
    logic                   lit_emit;
    logic [LEN_WIDTH-1:0]   run_taken;
    logic [LEN_WIDTH-1:0]   remain_after_run;
    logic [LEN_WIDTH-1:0]   size_minus_produced;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    // Nothing is done once the configured size has been produced.
    assign active   = accept && (remain_reg != '0);
    assign is_digit = (code_byte[BYTE_WIDTH-1:1] == '0);

    // Next accumulator value for a bijective digit; it sticks at all ones.
    always_comb
    begin
        if (!run_open_reg)
        begin
            acc_grown = COUNT_WIDTH'({1'b1, code_byte[0]});
        end
        else if (acc_reg[COUNT_WIDTH-1])
        begin
            acc_grown = '1;
        end
        else
        begin
            acc_grown = {acc_reg[COUNT_WIDTH-2:0], code_byte[0]};
        end
    end

    assign acc_sel = is_digit ? acc_grown : acc_reg;
    assign lit_val = (code_byte <= border_reg) ? (code_byte - BYTE_WIDTH'(1)) : code_byte;

    // Classification of the byte into a raw run and a raw literal.
    always_comb
    begin
        has_run_raw = 1'b0;
        has_lit_raw = 1'b0;
        run_raw     = acc_sel - COUNT_WIDTH'(1);
        if (mode_reg == MODE_COUNT_BYTE)
        begin
            if (await_reg)
            begin
                has_run_raw = 1'b1;
                run_raw     = COUNT_WIDTH'(code_byte);
            end
            else
            begin
                has_lit_raw = 1'b1;
            end
        end
        else
        begin
            if (is_digit)
            begin
                has_run_raw = end_of_stream;
            end
            else
            begin
                has_run_raw = run_open_reg;
                has_lit_raw = 1'b1;
            end
        end
    end

    // Clipping against the bytes that remain.
    assign run_ext          = CMP_WIDTH'(run_raw);
    assign run_ge           = (run_ext >= CMP_WIDTH'(remain_reg));
    assign run_clip         = run_ge ? remain_reg : run_ext[LEN_WIDTH-1:0];
    assign run_emit         = has_run_raw && (run_raw != '0);
    assign lit_emit         = has_lit_raw && !(has_run_raw && run_ge);
    assign run_taken        = run_emit ? run_clip : '0;
    assign remain_after_run = remain_reg - run_taken;

    assign push = active && (run_emit || lit_emit);

    always_comb
    begin
        push_cmd.has_run  = run_emit;
        push_cmd.run_len  = run_clip;
        push_cmd.run_full = run_ge;
        push_cmd.has_lit  = lit_emit;
        push_cmd.lit_val  = (mode_reg == MODE_COUNT_BYTE) ? code_byte : lit_val;
        push_cmd.lit_full = (remain_after_run == LEN_WIDTH'(1));
    end

    assign size_minus_produced = cfg_data - produced_reg;

    // Decoder state update. A new output size only changes the remaining
    // count, measured from what has been produced so far.
    always_comb
    begin
        run_open_next = run_open_reg;
        acc_next      = acc_reg;
        await_next    = await_reg;
        remain_next   = remain_reg;
        produced_next = produced_reg;
        if (active)
        begin
            remain_next   = remain_after_run - LEN_WIDTH'(lit_emit);
            produced_next = produced_reg + run_taken + LEN_WIDTH'(lit_emit);
            if (mode_reg == MODE_COUNT_BYTE)
            begin
                await_next = !await_reg && (code_byte == '0);
            end
            else if (is_digit)
            begin
                run_open_next = 1'b1;
                acc_next      = acc_grown;
            end
            else
            begin
                run_open_next = 1'b0;
                acc_next      = '0;
            end
            if (end_of_stream)
            begin
                run_open_next = 1'b0;
                acc_next      = '0;
                await_next    = 1'b0;
            end
        end
        if (cfg_write && (cfg_index == REG_OUTPUT_SIZE))
        begin
            remain_next = (cfg_data > produced_reg) ? size_minus_produced : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_COUNT_BYTE;
            border_reg   <= '0;
            produced_reg <= '0;
            remain_reg   <= '0;
            run_open_reg <= 1'b0;
            acc_reg      <= '0;
            await_reg    <= 1'b0;
        end
        else
        begin
            run_open_reg <= run_open_next;
            acc_reg      <= acc_next;
            await_reg    <= await_next;
            produced_reg <= produced_next;
            remain_reg   <= remain_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CODING_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                    end
                    REG_BORDER_SYMBOL:
                    begin
                        border_reg <= cfg_data[BYTE_WIDTH-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/core/zrld_queue.sv
// Small command queue that decouples the decoder front end from the back end.
// Depends on zrld_pkg.
module zrld_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  zrld_pkg::zrld_cmd_t        push_cmd,
    input  logic                       pop,
    output zrld_pkg::zrld_cmd_t        head_cmd,
    output zrld_pkg::zrld_q_status_t   status
);
    import zrld_pkg::*;

    zrld_cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_WIDTH-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_WIDTH'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_WIDTH'(1);
            end
            count_reg <= count_reg + QUEUE_CNT_WIDTH'(do_push) - QUEUE_CNT_WIDTH'(do_pop);
        end
    end

endmodule

>>> rtl/core/zrld_back.sv
// Back end of the zero run-length decoder: splits each command into one or
// two results and holds them in the output register. Depends on zrld_pkg.
module zrld_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  zrld_pkg::zrld_cmd_t                 head_cmd,
    input  zrld_pkg::zrld_q_status_t            q_status,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                item_kind,
    output logic [zrld_pkg::BYTE_WIDTH-1:0]     literal_value,
    output logic [zrld_pkg::LEN_WIDTH-1:0]      run_length,
    output logic                                last_of_item,
    output logic                                output_full
);
    import zrld_pkg::*;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  kind_reg;
    logic                  kind_next;
    logic [BYTE_WIDTH-1:0] value_reg;
    logic [BYTE_WIDTH-1:0] value_next;
    logic [LEN_WIDTH-1:0]  len_reg;
    logic [LEN_WIDTH-1:0]  len_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  full_reg;
    logic                  full_next;
    logic                  second_reg;
    logic                  second_next;

    logic load;
    logic two_part;
    logic send_run;

    assign load     = !out_valid_reg || out_ready;
    assign two_part = head_cmd.has_run && head_cmd.has_lit;
    // The run goes first; the literal of a two-part command follows it.
    assign send_run = head_cmd.has_run && !second_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (load && !q_status.empty)
        begin
            out_valid_next = 1'b1;
            if (send_run)
            begin
                kind_next  = KIND_RUN;
                value_next = '0;
                len_next   = head_cmd.run_len;
                full_next  = head_cmd.run_full;
                last_next  = !two_part;
            end
            else
            begin
                kind_next  = KIND_LITERAL;
                value_next = head_cmd.lit_val;
                len_next   = LEN_WIDTH'(1);
                full_next  = head_cmd.lit_full;
                last_next  = 1'b1;
            end
            pop         = !(send_run && two_part);
            second_next = send_run && two_part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
        full_reg  <= full_next;
    end

    assign out_valid     = out_valid_reg;
    assign item_kind     = kind_reg;
    assign literal_value = value_reg;
    assign run_length    = len_reg;
    assign last_of_item  = last_reg;
    assign output_full   = full_reg;

endmodule

>>> rtl/core/zero_run_length_decoder_core.sv
// Top level of the zero run-length decoder core.
// Instantiates zrld_front, zrld_queue and zrld_back; depends on zrld_pkg.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  -----------------------------------------
//  cfg       in         cfg_write (no wait)    cfg_index, cfg_data
//  in        in         in_valid / in_ready    code_byte, end_of_stream
//  out       out        out_valid / out_ready  item_kind, literal_value, run_length,
//                                              last_of_item, output_full
//
// The front end takes one input transaction per cycle while the queue is not full and decodes it
// in that cycle into a command of at most two results, which enters a four-entry queue. The back
// end sends one result per cycle while out_ready is high, so a byte that closes a run and is also
// a literal holds the back end for both of its results; the queue absorbs this.
// Reset is asynchronous and active low and needs no clearing pass.
// in_ready drops only while the queue is full; out_ready stalls only the back end.
module zero_run_length_decoder_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [zrld_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [zrld_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [zrld_pkg::BYTE_WIDTH-1:0]         code_byte,
    input  logic                                    end_of_stream,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    item_kind,
    output logic [zrld_pkg::BYTE_WIDTH-1:0]         literal_value,
    output logic [zrld_pkg::LEN_WIDTH-1:0]          run_length,
    output logic                                    last_of_item,
    output logic                                    output_full
);
    import zrld_pkg::*;

    zrld_q_status_t q_status;
    zrld_cmd_t      push_cmd;
    zrld_cmd_t      head_cmd;
    logic           push;
    logic           pop;

    // The front end owns the registers, the decoding state and the count of
    // produced bytes, so clipping is settled before a command is queued.
    zrld_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_byte     (code_byte),
        .end_of_stream (end_of_stream),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    zrld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // The back end turns each command into its results, run first.
    zrld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_kind     (item_kind),
        .literal_value (literal_value),
        .run_length    (run_length),
        .last_of_item  (last_of_item),
        .output_full   (output_full)
    );

`ifndef SYNTHESIS
    // Every queued command carries at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.has_run || push_cmd.has_lit))
        else $error("empty command queued");

    // A result that is not the last of its transaction is always a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_item) |-> (item_kind == KIND_RUN))
        else $error("non-final result is not a run");

    // A run sent as the first of two results is followed by its literal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_item) |=>
            (out_valid && (item_kind == KIND_LITERAL) && last_of_item))
        else $error("literal missing after split run");

    // Clipping never lets a result of zero bytes through.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != '0))
        else $error("zero length result");
`endif

endmodule
